// ===== hdl/psc_pkg.sv =====
// psc_pkg: shared constants, codes and helper functions of the piston setpoint controller
// no dependencies; used by the divider and the top level
package psc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int CFG_IDX_BITS = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_LIMITS_ON  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_POS    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_POS    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RATE_LIMIT = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POWER      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RATIO      = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODE       = 3'd6;

  // control modes
  localparam logic [1:0] MODE_STRICT   = 2'd1;
  localparam logic [1:0] MODE_ADAPTIVE = 2'd2;

  // row kinds
  localparam logic [2:0] ROW_MIDPOINT = 3'd0;
  localparam logic [2:0] ROW_ZERO     = 3'd1;
  localparam logic [2:0] ROW_BELOW    = 3'd2;
  localparam logic [2:0] ROW_ABOVE    = 3'd3;
  localparam logic [2:0] ROW_DRIVE    = 3'd4;
  localparam logic [2:0] ROW_BRAKE    = 3'd5;
  localparam logic [2:0] ROW_RESET    = 3'd6;

  localparam logic [16:0] RATIO_ONE = 17'd65536;

  typedef struct packed {
    logic        start;
    logic        neg;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } psc_div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [31:0] quot;
  } psc_div_rsp_t;

  // signed result from a magnitude, capped at the word range
  function automatic logic signed [31:0] sat_mag(input logic neg, input logic [63:0] m);
    logic signed [31:0] r;
    if (m >= 64'h8000_0000) begin
      r = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = neg ? -$signed(m[31:0]) : $signed(m[31:0]);
    end
    return r;
  endfunction

  // saturate a 34-bit signed value to the word
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      r = v[31:0];
    end else begin
      r = v[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

// ===== hdl/psc_tick_if.sv =====
// psc_tick_if: input item channel of the piston setpoint controller
// depends on nothing but the field widths
interface psc_tick_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [31:0] measured_position;
  logic [16:0]        tick_length;
  logic               drive_on;
  logic signed [31:0] drive_value;

  modport source (output valid, cmd, measured_position, tick_length, drive_on, drive_value,
                  input ready);
  modport sink (input valid, cmd, measured_position, tick_length, drive_on, drive_value,
                output ready);
endinterface

// ===== hdl/psc_result_if.sv =====
// psc_result_if: result item channel of the piston setpoint controller
// depends on nothing but the field widths
interface psc_result_if;
  logic               valid;
  logic               ready;
  logic [2:0]         row_kind;
  logic signed [31:0] row_offset;
  logic signed [31:0] row_accel;
  logic [30:0]        friction_bound;
  logic signed [31:0] position_now;
  logic signed [31:0] velocity_now;
  logic signed [31:0] accel_now;

  modport source (output valid, row_kind, row_offset, row_accel, friction_bound,
                  position_now, velocity_now, accel_now, input ready);
  modport sink (input valid, row_kind, row_offset, row_accel, friction_bound,
                position_now, velocity_now, accel_now, output ready);
endinterface

// ===== hdl/psc_cfg_if.sv =====
// psc_cfg_if: configuration write channel
// depends on nothing but the index and data widths
interface psc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/psc_div.sv =====
// psc_div: restoring divider, one quotient bit per cycle, saturated signed result
// depends on psc_pkg for the request and response structs and sat_mag
module psc_div (
  input  logic                  clk,
  input  logic                  rst,
  input  psc_pkg::psc_div_req_t req,
  output psc_pkg::psc_div_rsp_t rsp
);

  localparam int STEPS = 64;
  localparam int CNT_BITS = $clog2(STEPS);

  logic                busy;
  logic                done;
  logic [CNT_BITS-1:0] cnt;
  logic [63:0]         dvd;
  logic [31:0]         rem;
  logic [31:0]         dvs;
  logic                neg;

  logic [32:0] rem_sh;
  logic [33:0] diff;
  logic        ge;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    rem_sh = {rem, dvd[63]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs};
    ge     = ~diff[33];
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out while quotient bits shift in
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      neg <= req.neg;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[62:0], ge};
      rem <= ge ? diff[31:0] : rem_sh[31:0];
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = psc_pkg::sat_mag(neg, dvd);

endmodule

// ===== hdl/piston_setpoint_controller_top.sv =====
// piston_setpoint_controller_top: sequencer and datapath of the piston setpoint controller
// depends on psc_pkg, the three channel interfaces and psc_div
//
//   channel  dir  contents
//   tick     in   cmd, measured_position, tick_length, drive_on, drive_value
//   result   out  row_kind, row_offset, row_accel, friction_bound, position/velocity/accel
//   cfg      in   index, data (always ready)
//
// one item at a time; a control tick costs 2 to 5 passes of the shared divider
// plus multiply steps on the shared multiplier
// a disconnect item uses neither unit and goes straight to the output state
// reset is synchronous; it clears the state and loads the register defaults
// tick is ready whenever the sequencer is idle, even while a result waits on result.ready
module piston_setpoint_controller_top (
  input logic         clk,
  input logic         rst,
  psc_tick_if.sink    tick,
  psc_result_if.source result,
  psc_cfg_if.sink     cfg
);

  typedef enum logic [17:0] {
    S_IDLE    = 18'b000000000000000001,
    S_VEL     = 18'b000000000000000010,
    S_ACC     = 18'b000000000000000100,
    S_CLASS   = 18'b000000000000001000,
    S_M2_MUL  = 18'b000000000000010000,
    S_M2_NEXT = 18'b000000000000100000,
    S_M2_LIM  = 18'b000000000001000000,
    S_M1_MUL1 = 18'b000000000010000000,
    S_M1_MUL2 = 18'b000000000100000000,
    S_M1_DIV  = 18'b000000001000000000,
    S_M0_MRT  = 18'b000000010000000000,
    S_M0_DIV  = 18'b000000100000000000,
    S_M0_RMUL = 18'b000001000000000000,
    S_M0_RDIV = 18'b000010000000000000,
    S_RACC    = 18'b000100000000000000,
    S_OFF     = 18'b001000000000000000,
    S_BRAKE   = 18'b010000000000000000,
    S_OUT     = 18'b100000000000000000
  } state_t;

  state_t state;
  logic   issued;

  // configuration registers
  logic               limits_on;
  logic signed [31:0] min_position;
  logic signed [31:0] max_position;
  logic [30:0]        rate_limit;
  logic [30:0]        power_limit;
  logic [16:0]        reduction_ratio;
  logic [1:0]         control_mode;

  // persistent state
  logic signed [31:0] prev_position;
  logic signed [31:0] prev_velocity;
  logic signed [31:0] target_position;

  // working registers
  logic signed [31:0] pos;
  logic [16:0]        tlen;
  logic               drive_on;
  logic signed [31:0] ctrl;
  logic signed [31:0] vel;
  logic signed [31:0] acc;
  logic signed [31:0] dv;
  logic signed [31:0] tmp;
  logic signed [32:0] rel;
  logic [30:0]        mrt;
  logic               lim_hi;
  logic [2:0]         kind;
  logic signed [31:0] offset;
  logic signed [31:0] raccel;
  logic [30:0]        fric;

  // multiplier product register
  logic [63:0] prod;
  logic        pneg;

  // output register
  logic               out_valid;
  logic [2:0]         out_kind;
  logic signed [31:0] out_offset;
  logic signed [31:0] out_accel;
  logic [30:0]        out_fric;
  logic signed [31:0] out_pos;
  logic signed [31:0] out_vel;
  logic signed [31:0] out_acc;

  psc_pkg::psc_div_req_t div_req;
  psc_pkg::psc_div_rsp_t div_rsp;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic [31:0]        mul_am;
  logic [31:0]        mul_bm;
  logic signed [31:0] mq;
  logic signed [33:0] div_a;
  logic [33:0]        div_am;
  logic               div_state;

  logic               tick_acc;
  logic               out_free;
  logic signed [33:0] half_sum;
  logic signed [33:0] half;
  logic               inverted;
  logic               zero_range;
  logic signed [31:0] nx;
  logic [32:0]        abs_rel;
  logic [32:0]        abs_q;
  logic [32:0]        abs_dv;

  function automatic logic signed [31:0] clampv(input logic signed [31:0] v,
                                                input logic signed [31:0] lo,
                                                input logic signed [31:0] hi);
    logic signed [31:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [32:0] abs33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  assign tick.ready = (state == S_IDLE);
  assign tick_acc   = tick.valid && tick.ready;
  assign cfg.ready  = 1'b1;
  assign out_free   = !out_valid || result.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      limits_on       <= 1'b0;
      min_position    <= -32'sd655360;
      max_position    <= 32'sd655360;
      rate_limit      <= 31'd2621440;
      power_limit     <= '0;
      reduction_ratio <= 17'd6554;
      control_mode    <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        psc_pkg::CFG_LIMITS_ON:  limits_on    <= cfg.data[0];
        psc_pkg::CFG_MIN_POS:    min_position <= cfg.data;
        psc_pkg::CFG_MAX_POS:    max_position <= cfg.data;
        psc_pkg::CFG_RATE_LIMIT: rate_limit   <= cfg.data[30:0];
        psc_pkg::CFG_POWER:      power_limit  <= cfg.data[30:0];
        psc_pkg::CFG_RATIO: begin
          reduction_ratio <= (cfg.data[16:0] > psc_pkg::RATIO_ONE) ?
                             psc_pkg::RATIO_ONE : cfg.data[16:0];
        end
        psc_pkg::CFG_MODE:       control_mode <= cfg.data[1:0];
        default: ;
      endcase
    end
  end

  // multiplier operand select
  always_comb begin
    unique case (state)
      S_M2_MUL, S_M1_MUL1: begin
        mul_a = 33'({2'b00, rate_limit});
        mul_b = 33'(ctrl);
      end
      S_M2_NEXT, S_OFF: begin
        mul_a = 33'(dv);
        mul_b = 33'({16'b0, tlen});
      end
      S_M1_MUL2: begin
        mul_a = 33'(tmp);
        mul_b = 33'({16'b0, tlen});
      end
      S_M0_MRT: begin
        mul_a = 33'({2'b00, rate_limit});
        mul_b = 33'({16'b0, reduction_ratio});
      end
      S_M0_RMUL: begin
        mul_a = 33'({2'b00, rate_limit});
        mul_b = $signed(abs_rel);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_am = mul_a[32] ? 32'(-mul_a) : mul_a[31:0];
    mul_bm = mul_b[32] ? 32'(-mul_b) : mul_b[31:0];
    mq     = psc_pkg::sat_mag(pneg, {16'b0, prod[63:psc_pkg::FRAC_BITS]});
  end

  // divider request select
  always_comb begin
    div_state = 1'b1;
    unique case (state)
      S_VEL:    div_a = 34'(pos) - 34'(prev_position);
      S_ACC:    div_a = 34'(vel) - 34'(prev_velocity);
      S_M2_LIM: div_a = (lim_hi ? 34'(max_position) : 34'(min_position)) - 34'(pos);
      S_M1_DIV: div_a = 34'(target_position) - 34'(pos);
      S_M0_DIV: div_a = 34'(rel);
      S_RACC:   div_a = 34'(dv) - 34'(vel);
      S_BRAKE:  div_a = -34'(vel);
      S_M0_RDIV: div_a = '0;
      default: begin
        div_a     = '0;
        div_state = 1'b0;
      end
    endcase
    div_am = div_a[33] ? 34'(-div_a) : 34'(div_a);
    div_req.start = div_state && !issued;
    if (state == S_M0_RDIV) begin
      div_req.dividend = prod;
      div_req.divisor  = {1'b0, mrt};
      div_req.neg      = rel[32];
    end else begin
      div_req.dividend = {14'b0, div_am, 16'b0};
      div_req.divisor  = {15'b0, tlen};
      div_req.neg      = div_a[33];
    end
  end

  psc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // limit classification and helpers
  always_comb begin
    half_sum   = 34'(min_position) + 34'(max_position);
    half       = $signed(half_sum + {33'b0, half_sum[33]}) >>> 1;
    inverted   = min_position > max_position;
    zero_range = (34'(max_position) - 34'(min_position)) < 34'sd1;
    nx         = psc_pkg::sat34(34'(pos) + 34'(mq));
    abs_rel    = abs33(rel);
    abs_q      = abs33(33'(div_rsp.quot));
    abs_dv     = abs33(33'(dv));
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      issued          <= 1'b0;
      prev_position   <= '0;
      prev_velocity   <= '0;
      target_position <= '0;
    end else begin
      // handshake bookkeeping for the shared units
      if (div_req.start) begin
        issued <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (tick_acc) begin
            if (tick.cmd) begin
              prev_position   <= '0;
              prev_velocity   <= '0;
              target_position <= '0;
              kind   <= psc_pkg::ROW_RESET;
              offset <= '0;
              raccel <= '0;
              fric   <= '0;
              pos    <= '0;
              vel    <= '0;
              acc    <= '0;
              state  <= S_OUT;
            end else begin
              pos      <= tick.measured_position;
              tlen     <= (tick.tick_length == '0) ? 17'd1 : tick.tick_length;
              drive_on <= tick.drive_on;
              ctrl     <= tick.drive_value;
              state    <= S_VEL;
            end
          end
        end
        S_VEL: begin
          if (div_rsp.done) begin
            issued <= 1'b0;
            vel    <= div_rsp.quot;
            state  <= S_ACC;
          end
        end
        S_ACC: begin
          if (div_rsp.done) begin
            issued        <= 1'b0;
            acc           <= div_rsp.quot;
            prev_position <= pos;
            prev_velocity <= vel;
            state         <= S_CLASS;
          end
        end
        S_CLASS: begin
          raccel <= '0;
          fric   <= '0;
          if (limits_on && inverted) begin
            kind   <= psc_pkg::ROW_MIDPOINT;
            offset <= psc_pkg::sat34(half - 34'(pos));
            state  <= S_OUT;
          end else if (limits_on && zero_range) begin
            kind   <= psc_pkg::ROW_ZERO;
            offset <= psc_pkg::sat34(-34'(pos));
            state  <= S_OUT;
          end else if (limits_on && pos < min_position) begin
            kind   <= psc_pkg::ROW_BELOW;
            offset <= psc_pkg::sat34(34'(min_position) - 34'(pos) + 34'sd1);
            state  <= S_OUT;
          end else if (limits_on && pos > max_position) begin
            kind   <= psc_pkg::ROW_ABOVE;
            offset <= psc_pkg::sat34(34'(max_position) - 34'(pos) - 34'sd1);
            state  <= S_OUT;
          end else begin
            fric <= (power_limit == '0) ? 31'h7FFF_FFFF : power_limit;
            if (!drive_on) begin
              state <= S_BRAKE;
            end else if (control_mode == psc_pkg::MODE_ADAPTIVE) begin
              state <= S_M2_MUL;
            end else if (control_mode == psc_pkg::MODE_STRICT) begin
              state <= S_M1_MUL1;
            end else begin
              state <= S_M0_MRT;
            end
          end
        end
        S_M2_MUL: begin
          if (!issued) begin
            issued <= 1'b1;
          end else begin
            issued          <= 1'b0;
            dv              <= mq;
            target_position <= pos;
            state           <= limits_on ? S_M2_NEXT : S_RACC;
          end
        end
        S_M2_NEXT: begin
          if (!issued) begin
            issued <= 1'b1;
          end else begin
            issued <= 1'b0;
            if (nx < min_position) begin
              lim_hi <= 1'b0;
              state  <= S_M2_LIM;
            end else if (nx > max_position) begin
              lim_hi <= 1'b1;
              state  <= S_M2_LIM;
            end else begin
              state <= S_RACC;
            end
          end
        end
        S_M2_LIM: begin
          if (div_rsp.done) begin
            issued <= 1'b0;
            dv     <= div_rsp.quot;
            state  <= S_RACC;
          end
        end
        S_M1_MUL1: begin
          if (!issued) begin
            issued <= 1'b1;
          end else begin
            issued <= 1'b0;
            tmp    <= mq;
            state  <= S_M1_MUL2;
          end
        end
        S_M1_MUL2: begin
          if (!issued) begin
            issued <= 1'b1;
          end else begin
            issued <= 1'b0;
            if (limits_on) begin
              target_position <= clampv(psc_pkg::sat34(34'(target_position) + 34'(mq)),
                                        min_position, max_position);
            end else begin
              target_position <= psc_pkg::sat34(34'(target_position) + 34'(mq));
            end
            state <= S_M1_DIV;
          end
        end
        S_M1_DIV: begin
          if (div_rsp.done) begin
            issued <= 1'b0;
            dv     <= div_rsp.quot;
            state  <= S_RACC;
          end
        end
        S_M0_MRT: begin
          if (!issued) begin
            issued          <= 1'b1;
            target_position <= limits_on ? clampv(ctrl, min_position, max_position) : ctrl;
          end else begin
            issued <= 1'b0;
            mrt    <= mq[30:0];
            rel    <= 33'(target_position) - 33'(pos);
            state  <= S_M0_DIV;
          end
        end
        S_M0_DIV: begin
          if (div_rsp.done) begin
            issued <= 1'b0;
            if (mrt != '0 && abs_rel < {2'b00, mrt}) begin
              dv    <= div_rsp.quot;
              state <= S_M0_RMUL;
            end else begin
              if (abs_q > {2'b00, rate_limit}) begin
                dv <= rel[32] ? -$signed({1'b0, rate_limit}) : $signed({1'b0, rate_limit});
              end else begin
                dv <= div_rsp.quot;
              end
              state <= S_RACC;
            end
          end
        end
        S_M0_RMUL: begin
          if (!issued) begin
            issued <= 1'b1;
          end else begin
            issued <= 1'b0;
            state  <= S_M0_RDIV;
          end
        end
        S_M0_RDIV: begin
          if (div_rsp.done) begin
            issued <= 1'b0;
            if (abs_q < abs_dv) begin
              dv <= div_rsp.quot;
            end
            state <= S_RACC;
          end
        end
        S_RACC: begin
          if (div_rsp.done) begin
            issued <= 1'b0;
            raccel <= div_rsp.quot;
            state  <= S_OFF;
          end
        end
        S_OFF: begin
          if (!issued) begin
            issued <= 1'b1;
          end else begin
            issued <= 1'b0;
            offset <= mq;
            kind   <= psc_pkg::ROW_DRIVE;
            state  <= S_OUT;
          end
        end
        S_BRAKE: begin
          if (div_rsp.done) begin
            issued <= 1'b0;
            raccel <= div_rsp.quot;
            offset <= '0;
            kind   <= psc_pkg::ROW_BRAKE;
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // product register of the shared multiplier
  always_ff @(posedge clk) begin
    if (!issued) begin
      prod <= mul_am * mul_bm;
      pneg <= mul_a[32] ^ mul_b[32];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_kind   <= kind;
      out_offset <= offset;
      out_accel  <= raccel;
      out_fric   <= fric;
      out_pos    <= pos;
      out_vel    <= vel;
      out_acc    <= acc;
    end
  end

  assign result.valid          = out_valid;
  assign result.row_kind       = out_kind;
  assign result.row_offset     = out_offset;
  assign result.row_accel      = out_accel;
  assign result.friction_bound = out_fric;
  assign result.position_now   = out_pos;
  assign result.velocity_now   = out_vel;
  assign result.accel_now      = out_acc;

  // checks
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state not one-hot");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !div_rsp.busy)
    else $error("divider busy while sequencer idle");

  a_disconnect_clears: assert property (@(posedge clk) disable iff (rst)
    tick_acc && tick.cmd |=> prev_position == '0 && prev_velocity == '0 &&
                             target_position == '0)
    else $error("disconnect item left state behind");

  a_reset_row_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == psc_pkg::ROW_RESET |-> out_offset == '0 && out_accel == '0 &&
                                                    out_fric == '0 && out_vel == '0)
    else $error("reset row carries nonzero fields");

endmodule
